/* sv/pn_counter_crdt_top_defines.svh */
// assertion macros shared by the pn counter rtl
`ifndef PN_COUNTER_CRDT_TOP_DEFINES_SVH
`define PN_COUNTER_CRDT_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PNC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define PNC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/pnc_pkg.sv */
// types, codes and helpers for the pn counter block
package pnc_pkg;

   localparam int DATA_W = 64;
   localparam int NODE_W = 4;
   localparam int CNT_W  = 5;
   localparam int ACT_W  = 3;
   localparam int CSR_W  = 2;
   localparam int WIDE_W = 9;

   localparam logic [ACT_W-1:0] ACT_INC   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DEC   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_MERGE = 3'd2;
   localparam logic [ACT_W-1:0] ACT_READ  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

   localparam logic [CSR_W-1:0] CSR_SELF_NODE  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_NODE_COUNT = 2'd1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_RD    = 6'b000010,
      ST_MOD   = 6'b000100,
      ST_SUM   = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n,
                                                    input logic [WIDE_W-1:0] lim);
      logic [WIDE_W-1:0] n_wide;
      n_wide = {{(WIDE_W-CNT_W){1'b0}}, n};
      clamp_count = (n_wide > lim) ? lim[CNT_W-1:0] : n;
   endfunction

endpackage

/* sv/pnc_ram.sv */
// generic single write port ram with registered read
module pnc_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/pn_counter_crdt_top.sv */
// pn counter replica: per-node counter pairs in one ram, update, merge, read, clear
//
//   channel  ports                         handshake
//   request  start, busy, req_*            taken when start and not busy
//   result   rsp_strobe, rsp_*             one beat per item, one cycle, no stall
//   csr      csr_we, csr_index, csr_wdata  written when csr_we
//
// increment, decrement, merge in range: ram read, modify and write back
// dropped items, clear, undefined actions, read with no active node: answered from idle
// read: one ram entry per cycle over the active nodes into two accumulators
// clear zeroes per-entry valid flops, which mark ram entries as zero until written
// reset is synchronous; the result side cannot stall
`include "pn_counter_crdt_top_defines.svh"

module pn_counter_crdt_top #(
   parameter int MAX_NODES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_action,
   input  logic [63:0]         req_amount,
   input  logic [3:0]          req_node_index,
   input  logic [63:0]         req_remote_positive,
   input  logic [63:0]         req_remote_negative,
   input  logic [4:0]          req_remote_node_count,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [4:0]          csr_wdata,
   output logic                rsp_strobe,
   output logic signed [63:0]  rsp_total,
   output logic                rsp_ignored
);

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int DW = pnc_pkg::DATA_W;
   localparam int CW = pnc_pkg::CNT_W;
   localparam int WW = pnc_pkg::WIDE_W;
   localparam logic [WW-1:0] MAX_W = WW'(MAX_NODES);
   localparam logic [CW-1:0] RST_ACTIVE = (MAX_NODES < 16) ? CW'(MAX_NODES) : 5'd16;

   pnc_pkg::state_type state_ff, state_in;

   logic [3:0]              self_ff, self_in;
   logic [CW-1:0]           ncount_ff, ncount_in;
   logic [CW-1:0]           active_ff, active_in;
   logic [2:0]              act_ff, act_in;
   logic [DW-1:0]           amount_ff, amount_in;
   logic [DW-1:0]           rpos_ff, rpos_in;
   logic [DW-1:0]           rneg_ff, rneg_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    pend_ff, pend_in;
   logic [DW-1:0]           pos_acc_ff, pos_acc_in;
   logic [DW-1:0]           neg_acc_ff, neg_acc_in;
   logic [MAX_NODES-1:0]    vld_ff, vld_in;
   logic                    rvld_ff, rvld_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]           rsp_total_ff, rsp_total_in;
   logic                    rsp_ign_ff, rsp_ign_in;

   logic                    ram_we;
   logic [AW-1:0]           ram_raddr;
   logic [2*DW-1:0]         ram_wdata;
   logic [2*DW-1:0]         ram_rdata;

   logic [WW-1:0]           self_wide, idx_wide, cnt_wide;
   logic [CW-1:0]           rcount, span;
   logic                    self_ok, idx_ok;
   logic [DW-1:0]           cur_pos, cur_neg, new_pos, new_neg;

   pnc_ram #(
      .WIDTH (2*DW),
      .DEPTH (MAX_NODES)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign self_wide = {{(WW-4){1'b0}}, self_ff};
   assign idx_wide  = {{(WW-4){1'b0}}, req_node_index};
   assign cnt_wide  = {{(WW-CW){1'b0}}, cnt_ff};
   assign rcount    = pnc_pkg::clamp_count(req_remote_node_count, MAX_W);
   assign span      = (active_ff > rcount) ? active_ff : rcount;
   assign self_ok   = ({1'b0, self_ff} < active_ff) && (self_wide < MAX_W);
   assign idx_ok    = ({1'b0, req_node_index} < span) && (idx_wide < MAX_W);

   // entries never written since clear read as zero
   assign cur_pos = rvld_ff ? ram_rdata[2*DW-1:DW] : '0;
   assign cur_neg = rvld_ff ? ram_rdata[DW-1:0]    : '0;

   always_comb begin
      new_pos = cur_pos;
      new_neg = cur_neg;
      case (act_ff)
         pnc_pkg::ACT_INC: begin
            new_pos = cur_pos + amount_ff;
         end
         pnc_pkg::ACT_DEC: begin
            new_neg = cur_neg + amount_ff;
         end
         pnc_pkg::ACT_MERGE: begin
            new_pos = (rpos_ff > cur_pos) ? rpos_ff : cur_pos;
            new_neg = (rneg_ff > cur_neg) ? rneg_ff : cur_neg;
         end
         default: begin
            new_pos = cur_pos;
            new_neg = cur_neg;
         end
      endcase
   end

   assign ram_wdata = {new_pos, new_neg};

   always_comb begin
      state_in     = state_ff;
      self_in      = self_ff;
      ncount_in    = ncount_ff;
      active_in    = active_ff;
      act_in       = act_ff;
      amount_in    = amount_ff;
      rpos_in      = rpos_ff;
      rneg_in      = rneg_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      vld_in       = vld_ff;
      rsp_valid_in = 1'b0;
      rsp_total_in = rsp_total_ff;
      rsp_ign_in   = rsp_ign_ff;
      ram_we       = 1'b0;
      ram_raddr    = addr_ff;
      pend_in      = (state_ff == pnc_pkg::ST_SUM);
      pos_acc_in   = pos_acc_ff;
      neg_acc_in   = neg_acc_ff;

      // accumulate the entry read in the previous walk cycle
      if (pend_ff) begin
         pos_acc_in = pos_acc_ff + cur_pos;
         neg_acc_in = neg_acc_ff + cur_neg;
      end

      if (csr_we) begin
         case (csr_index)
            pnc_pkg::CSR_SELF_NODE:  self_in   = csr_wdata[3:0];
            pnc_pkg::CSR_NODE_COUNT: ncount_in = csr_wdata;
            default: begin
               self_in   = self_ff;
               ncount_in = ncount_ff;
            end
         endcase
      end

      case (state_ff)
         pnc_pkg::ST_IDLE: begin
            if (start) begin
               act_in       = req_action;
               amount_in    = req_amount;
               rpos_in      = req_remote_positive;
               rneg_in      = req_remote_negative;
               rsp_total_in = '0;
               rsp_ign_in   = 1'b0;
               case (req_action)
                  pnc_pkg::ACT_INC, pnc_pkg::ACT_DEC: begin
                     if (self_ok) begin
                        addr_in  = self_wide[AW-1:0];
                        state_in = pnc_pkg::ST_RD;
                     end else begin
                        rsp_ign_in   = 1'b1;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  pnc_pkg::ACT_MERGE: begin
                     if (idx_ok) begin
                        addr_in  = idx_wide[AW-1:0];
                        state_in = pnc_pkg::ST_RD;
                     end else begin
                        rsp_ign_in   = 1'b1;
                        rsp_valid_in = 1'b1;
                     end
                     if (rcount > active_ff) begin
                        active_in = rcount;
                     end
                  end
                  pnc_pkg::ACT_READ: begin
                     pos_acc_in = '0;
                     neg_acc_in = '0;
                     cnt_in     = '0;
                     if (active_ff != '0) begin
                        state_in = pnc_pkg::ST_SUM;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  pnc_pkg::ACT_CLEAR: begin
                     vld_in       = '0;
                     active_in    = pnc_pkg::clamp_count(ncount_ff, MAX_W);
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_ign_in   = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         pnc_pkg::ST_RD: begin
            state_in = pnc_pkg::ST_MOD;
         end
         pnc_pkg::ST_MOD: begin
            ram_we          = 1'b1;
            vld_in[addr_ff] = 1'b1;
            rsp_valid_in    = 1'b1;
            state_in        = pnc_pkg::ST_IDLE;
         end
         pnc_pkg::ST_SUM: begin
            ram_raddr = cnt_wide[AW-1:0];
            cnt_in    = cnt_ff + 5'd1;
            if (cnt_ff == active_ff - 5'd1) begin
               state_in = pnc_pkg::ST_DRAIN;
            end
         end
         pnc_pkg::ST_DRAIN: begin
            state_in = pnc_pkg::ST_FIN;
         end
         pnc_pkg::ST_FIN: begin
            rsp_total_in = pos_acc_ff - neg_acc_ff;
            rsp_valid_in = 1'b1;
            state_in     = pnc_pkg::ST_IDLE;
         end
         default: begin
            state_in = pnc_pkg::ST_IDLE;
         end
      endcase

      rvld_in = vld_ff[ram_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pnc_pkg::ST_IDLE;
         self_ff      <= '0;
         ncount_ff    <= 5'd16;
         active_ff    <= RST_ACTIVE;
         vld_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         self_ff      <= self_in;
         ncount_ff    <= ncount_in;
         active_ff    <= active_in;
         vld_ff       <= vld_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      amount_ff    <= amount_in;
      rpos_ff      <= rpos_in;
      rneg_ff      <= rneg_in;
      addr_ff      <= addr_in;
      cnt_ff       <= cnt_in;
      pos_acc_ff   <= pos_acc_in;
      neg_acc_ff   <= neg_acc_in;
      rvld_ff      <= rvld_in;
      rsp_total_ff <= rsp_total_in;
      rsp_ign_ff   <= rsp_ign_in;
   end

   assign busy        = (state_ff != pnc_pkg::ST_IDLE);
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_total   = $signed(rsp_total_ff);
   assign rsp_ignored = rsp_ign_ff;

   `PNC_ASSERT_NEXT(a_accept, clock, reset, start && !busy, busy || rsp_valid_ff, "beat lost")
   `PNC_ASSERT_NOW(a_cap, clock, reset, 1'b1, {{(WW-CW){1'b0}}, active_ff} <= MAX_W, "count high")
   `PNC_ASSERT_NOW(a_write_mod, clock, reset, ram_we, state_ff == pnc_pkg::ST_MOD, "stray write")
   `PNC_ASSERT_NOW(a_walk, clock, reset, state_ff == pnc_pkg::ST_SUM, cnt_ff < active_ff, "overrun")
   `PNC_ASSERT_NEXT(a_fin, clock, reset, state_ff == pnc_pkg::ST_FIN, rsp_valid_ff && !busy, "lost")

endmodule
